>>> design/ttpt_pkg.sv
package ttpt_pkg;

  // Ratio fraction bits, default for the top-level parameter
  localparam int unsigned RatioFracBits = 16;

  // Fixed field widths
  localparam int unsigned IdW     = 8;
  localparam int unsigned PosW    = 16;
  localparam int unsigned SpreadW = 17;
  localparam int unsigned RatioW  = 24;
  localparam int unsigned SqW     = 34;
  localparam int unsigned RemW    = 20;

  localparam logic [RatioW-1:0] RatioMax = '1;

  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_MOVE  = 2'd1,
    ACT_END   = 2'd2,
    ACT_RESET = 2'd3
  } action_e;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_CALC
  } top_state_e;

  typedef enum logic [2:0] {
    AR_IDLE,
    AR_SQX,
    AR_SQY,
    AR_ROOT,
    AR_DIV,
    AR_DONE
  } ar_state_e;

  typedef struct packed {
    logic                   valid;
    logic signed [IdW-1:0]  id;
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
  } slot_t;

  typedef struct packed {
    action_e                action;
    logic signed [IdW-1:0]  id;
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
  } event_t;

  // What an event asks of the rest of the block
  typedef struct packed {
    logic calc;      // spread needed
    logic ratio;     // ratio needed as well, if both spreads are nonzero
    logic clr_last;  // clear the stored spread
  } plan_t;

  // Status and results of the arithmetic unit
  typedef struct packed {
    logic                done;
    logic                upd;
    logic [SpreadW-1:0]  spread;
    logic [RatioW-1:0]   ratio;
  } ar_res_t;

  typedef struct packed {
    logic                   update_valid;
    logic [RatioW-1:0]      zoom_ratio;
    logic signed [PosW-1:0] mid_x;
    logic signed [PosW-1:0] mid_y;
    logic                   pinch_active;
    logic                   id_tracked;
    logic                   single_present;
    logic signed [IdW-1:0]  single_id;
    logic signed [PosW-1:0] single_x;
    logic signed [PosW-1:0] single_y;
  } res_t;

endpackage

>>> design/ttpt_if.sv
interface ttpt_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic signed [7:0] touch_id;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;

  modport source (output valid, action, touch_id, pos_x, pos_y, input ready);
  modport sink (input valid, action, touch_id, pos_x, pos_y, output ready);
endinterface

interface ttpt_out_if;
  logic               valid;
  logic               ready;
  logic               update_valid;
  logic [23:0]        zoom_ratio;
  logic signed [15:0] mid_x;
  logic signed [15:0] mid_y;
  logic               pinch_active;
  logic               id_tracked;
  logic               single_present;
  logic signed [7:0]  single_id;
  logic signed [15:0] single_x;
  logic signed [15:0] single_y;

  modport source (
    output valid, update_valid, zoom_ratio, mid_x, mid_y, pinch_active, id_tracked,
           single_present, single_id, single_x, single_y,
    input  ready
  );
  modport sink (
    input  valid, update_valid, zoom_ratio, mid_x, mid_y, pinch_active, id_tracked,
           single_present, single_id, single_x, single_y,
    output ready
  );
endinterface

>>> design/ttpt_slots.sv
module ttpt_slots (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  apply_i,
  input  ttpt_pkg::event_t      ev_i,
  output ttpt_pkg::slot_t       slot_a_o,
  output ttpt_pkg::slot_t       slot_b_o,
  output ttpt_pkg::plan_t       plan_o
);

  ttpt_pkg::slot_t a_q, a_d, b_q, b_d;
  logic            hit_a, hit_b;

  assign hit_a = a_q.valid && (a_q.id == ev_i.id);
  assign hit_b = b_q.valid && (b_q.id == ev_i.id);

  // Work out the slot contents after the event
  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    plan_o = '0;
    if (ev_i.action == ttpt_pkg::ACT_RESET) begin
      a_d             = '0;
      b_d             = '0;
      plan_o.clr_last = 1'b1;
    end else if (!ev_i.id[ttpt_pkg::IdW-1]) begin
      case (ev_i.action)
        ttpt_pkg::ACT_BEGIN: begin
          if (hit_a) begin
            a_d.x = ev_i.x;
            a_d.y = ev_i.y;
          end else if (hit_b) begin
            b_d.x = ev_i.x;
            b_d.y = ev_i.y;
          end else if (!a_q.valid) begin
            a_d = '{valid: 1'b1, id: ev_i.id, x: ev_i.x, y: ev_i.y};
          end else if (!b_q.valid) begin
            b_d         = '{valid: 1'b1, id: ev_i.id, x: ev_i.x, y: ev_i.y};
            plan_o.calc = 1'b1;
          end
        end
        ttpt_pkg::ACT_MOVE: begin
          if (hit_a) begin
            a_d.x = ev_i.x;
            a_d.y = ev_i.y;
          end else if (hit_b) begin
            b_d.x = ev_i.x;
            b_d.y = ev_i.y;
          end
          if ((hit_a || hit_b) && a_q.valid && b_q.valid) begin
            plan_o.calc  = 1'b1;
            plan_o.ratio = 1'b1;
          end
        end
        ttpt_pkg::ACT_END: begin
          // promote the second contact when the first one lifts
          if (hit_a) begin
            a_d             = b_q;
            b_d             = '0;
            plan_o.clr_last = 1'b1;
          end else if (hit_b) begin
            b_d             = '0;
            plan_o.clr_last = 1'b1;
          end
        end
        default: begin
          a_d = a_q;
        end
      endcase
    end
  end

  // Hold the slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
    end else if (apply_i) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign slot_a_o = a_q;
  assign slot_b_o = b_q;

endmodule

>>> design/ttpt_cmpsub.sv
module ttpt_cmpsub (
  input  logic [ttpt_pkg::RemW-1:0] a_i,
  input  logic [ttpt_pkg::RemW-1:0] b_i,
  output logic [ttpt_pkg::RemW-1:0] diff_o,
  output logic                      ge_o
);

  logic [ttpt_pkg::RemW:0] full;

  // Subtract with borrow; no borrow means a >= b
  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[ttpt_pkg::RemW-1:0];
  assign ge_o   = ~full[ttpt_pkg::RemW];

endmodule

>>> design/ttpt_arith.sv
module ttpt_arith #(
  parameter int unsigned RATIO_FRAC_BITS = ttpt_pkg::RatioFracBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          div_en_i,
  input  logic [ttpt_pkg::SpreadW-1:0]  last_i,
  input  ttpt_pkg::slot_t               slot_a_i,
  input  ttpt_pkg::slot_t               slot_b_i,
  output ttpt_pkg::ar_res_t             res_o
);

  localparam int unsigned NumW = ttpt_pkg::SpreadW + RATIO_FRAC_BITS;
  localparam int unsigned ShW  = (NumW > ttpt_pkg::SqW) ? NumW : ttpt_pkg::SqW;
  localparam int unsigned CntW = $clog2(NumW);
  localparam int unsigned RemW = ttpt_pkg::RemW;
  localparam int unsigned SpW  = ttpt_pkg::SpreadW;

  ttpt_pkg::ar_state_e state_q, state_d;

  logic [ShW-1:0]           sh_q, sh_d;
  logic [RemW-1:0]          rem_q, rem_d;
  logic [NumW-1:0]          acc_q, acc_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [ttpt_pkg::SqW-1:0] sq_q, sq_d;
  logic [SpW-1:0]           last_q, last_d, spread_q, spread_d;
  logic                     div_en_q, div_en_d, upd_q, upd_d;

  logic signed [SpW-1:0]      dx, dy, mul_op;
  logic signed [2*SpW-1:0]    prod;
  logic [ttpt_pkg::SqW-1:0]   sum;
  logic [RemW-1:0]            rem_in, trial, diff;
  logic                       ge;
  logic [NumW-1:0]            acc_step;
  logic [SpW-1:0]             root_new;

  assign dx     = SpW'(slot_b_i.x) - SpW'(slot_a_i.x);
  assign dy     = SpW'(slot_b_i.y) - SpW'(slot_a_i.y);
  assign mul_op = (state_q == ttpt_pkg::AR_SQX) ? dx : dy;
  assign prod   = mul_op * mul_op;
  assign sum    = sq_q + ttpt_pkg::SqW'(prod);

  // Root steps take two bits, division steps one
  always_comb begin
    if (state_q == ttpt_pkg::AR_ROOT) begin
      rem_in = {rem_q[RemW-3:0], sh_q[ShW-1 -: 2]};
      trial  = {1'b0, acc_q[SpW-1:0], 2'b01};
    end else begin
      rem_in = {rem_q[RemW-2:0], sh_q[ShW-1]};
      trial  = RemW'(last_q);
    end
  end

  ttpt_cmpsub u_cmpsub (
    .a_i    (rem_in),
    .b_i    (trial),
    .diff_o (diff),
    .ge_o   (ge)
  );

  assign acc_step = {acc_q[NumW-2:0], ge};
  assign root_new = acc_step[SpW-1:0];

  // Sequence squares, root and division
  always_comb begin
    state_d  = state_q;
    sh_d     = sh_q;
    rem_d    = rem_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    sq_d     = sq_q;
    last_d   = last_q;
    spread_d = spread_q;
    div_en_d = div_en_q;
    upd_d    = upd_q;
    case (state_q)
      ttpt_pkg::AR_IDLE: begin
        if (start_i) begin
          div_en_d = div_en_i;
          last_d   = last_i;
          upd_d    = 1'b0;
          state_d  = ttpt_pkg::AR_SQX;
        end
      end
      ttpt_pkg::AR_SQX: begin
        sq_d    = ttpt_pkg::SqW'(prod);
        state_d = ttpt_pkg::AR_SQY;
      end
      ttpt_pkg::AR_SQY: begin
        sh_d    = ShW'(sum) << (ShW - ttpt_pkg::SqW);
        rem_d   = '0;
        acc_d   = '0;
        cnt_d   = '0;
        state_d = ttpt_pkg::AR_ROOT;
      end
      ttpt_pkg::AR_ROOT: begin
        sh_d  = sh_q << 2;
        rem_d = ge ? diff : rem_in;
        acc_d = acc_step;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(SpW - 1)) begin
          spread_d = root_new;
          if (div_en_q && (root_new != '0) && (last_q != '0)) begin
            sh_d    = ShW'(root_new) << (ShW - SpW);
            rem_d   = '0;
            acc_d   = '0;
            cnt_d   = '0;
            upd_d   = 1'b1;
            state_d = ttpt_pkg::AR_DIV;
          end else begin
            state_d = ttpt_pkg::AR_DONE;
          end
        end
      end
      ttpt_pkg::AR_DIV: begin
        sh_d  = sh_q << 1;
        rem_d = ge ? diff : rem_in;
        acc_d = acc_step;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(NumW - 1)) begin
          state_d = ttpt_pkg::AR_DONE;
        end
      end
      ttpt_pkg::AR_DONE: begin
        state_d = ttpt_pkg::AR_IDLE;
      end
      default: begin
        state_d = ttpt_pkg::AR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ttpt_pkg::AR_IDLE;
      div_en_q <= 1'b0;
      upd_q    <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      div_en_q <= div_en_d;
      upd_q    <= upd_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q     <= sh_d;
    rem_q    <= rem_d;
    acc_q    <= acc_d;
    sq_q     <= sq_d;
    last_q   <= last_d;
    spread_q <= spread_d;
  end

  // Status and spread out; saturate the quotient to the result width
  assign res_o.done   = (state_q == ttpt_pkg::AR_DONE);
  assign res_o.upd    = upd_q;
  assign res_o.spread = spread_q;
  assign res_o.ratio  = (|acc_q[NumW-1:ttpt_pkg::RatioW]) ? ttpt_pkg::RatioMax
                                                          : acc_q[ttpt_pkg::RatioW-1:0];

endmodule

>>> design/two_touch_pinch_tracker.sv
// Channel  Dir  Modport  Payload
// in_i     in   sink     action, touch_id, pos_x, pos_y
// out_o    out  source   update_valid, zoom_ratio, mid_x/y, status, single contact
//
// One item at a time. Events that need no spread go from accept through ST_CALC to a registered result.
// A spread (second begin, or a move with two contacts) adds two squares
// through one multiplier and 17 root steps on the shared compare-subtract unit.
// A ratio adds 17 + RATIO_FRAC_BITS division steps on the same unit. Reset clears slots
// and stored spread. A result waiting at out_o holds in_i.ready low until it is taken.
module two_touch_pinch_tracker #(
  parameter int unsigned RATIO_FRAC_BITS = ttpt_pkg::RatioFracBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ttpt_in_if.sink    in_i,
  ttpt_out_if.source out_o
);

  ttpt_pkg::top_state_e state_q, state_d;

  ttpt_pkg::event_t  ev;
  ttpt_pkg::slot_t   slot_a, slot_b;
  ttpt_pkg::plan_t   plan;
  ttpt_pkg::ar_res_t ar_res;
  ttpt_pkg::res_t    res_q, res_d;

  logic                             in_acc, out_valid_q, out_valid_d, finish;
  logic                             calc_q, calc_d;
  logic signed [ttpt_pkg::IdW-1:0]  id_q, id_d;
  logic [ttpt_pkg::SpreadW-1:0]     last_q, last_d;
  logic signed [ttpt_pkg::PosW:0]   sum_x, sum_y;
  logic                             single;

  assign ev = '{action: ttpt_pkg::action_e'(in_i.action), id: in_i.touch_id,
                x: in_i.pos_x, y: in_i.pos_y};

  assign in_i.ready = (state_q == ttpt_pkg::ST_IDLE) && !out_valid_q;
  assign in_acc     = in_i.valid && in_i.ready;

  ttpt_slots u_slots (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .apply_i  (in_acc),
    .ev_i     (ev),
    .slot_a_o (slot_a),
    .slot_b_o (slot_b),
    .plan_o   (plan)
  );

  ttpt_arith #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc && plan.calc),
    .div_en_i (plan.ratio),
    .last_i   (last_q),
    .slot_a_i (slot_a),
    .slot_b_i (slot_b),
    .res_o    (ar_res)
  );

  // Floor midpoint of the two contacts
  assign sum_x  = {slot_a.x[ttpt_pkg::PosW-1], slot_a.x} + {slot_b.x[ttpt_pkg::PosW-1], slot_b.x};
  assign sum_y  = {slot_a.y[ttpt_pkg::PosW-1], slot_a.y} + {slot_b.y[ttpt_pkg::PosW-1], slot_b.y};
  assign single = slot_a.valid && !slot_b.valid;
  assign finish = (state_q == ttpt_pkg::ST_CALC) && (!calc_q || ar_res.done);

  // Step the event through, collect the result
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    calc_d      = calc_q;
    id_d        = id_q;
    last_d      = last_q;
    res_d       = res_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ttpt_pkg::ST_IDLE: begin
        if (in_acc) begin
          calc_d  = plan.calc;
          id_d    = in_i.touch_id;
          if (plan.clr_last) begin
            last_d = '0;
          end
          state_d = ttpt_pkg::ST_CALC;
        end
      end
      ttpt_pkg::ST_CALC: begin
        if (finish) begin
          res_d.update_valid   = calc_q && ar_res.upd;
          res_d.zoom_ratio     = (calc_q && ar_res.upd) ? ar_res.ratio : '0;
          res_d.mid_x          = (calc_q && ar_res.upd) ? sum_x[ttpt_pkg::PosW:1] : '0;
          res_d.mid_y          = (calc_q && ar_res.upd) ? sum_y[ttpt_pkg::PosW:1] : '0;
          res_d.pinch_active   = slot_a.valid && slot_b.valid;
          res_d.id_tracked     = (slot_a.valid && (slot_a.id == id_q))
                               || (slot_b.valid && (slot_b.id == id_q));
          res_d.single_present = single;
          res_d.single_id      = single ? slot_a.id : '0;
          res_d.single_x       = single ? slot_a.x : '0;
          res_d.single_y       = single ? slot_a.y : '0;
          if (calc_q) begin
            last_d = ar_res.spread;
          end
          out_valid_d = 1'b1;
          state_d     = ttpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ttpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ttpt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      calc_q      <= 1'b0;
      last_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      calc_q      <= calc_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    res_q <= res_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.update_valid   = res_q.update_valid;
  assign out_o.zoom_ratio     = res_q.zoom_ratio;
  assign out_o.mid_x          = res_q.mid_x;
  assign out_o.mid_y          = res_q.mid_y;
  assign out_o.pinch_active   = res_q.pinch_active;
  assign out_o.id_tracked     = res_q.id_tracked;
  assign out_o.single_present = res_q.single_present;
  assign out_o.single_id      = res_q.single_id;
  assign out_o.single_x       = res_q.single_x;
  assign out_o.single_y       = res_q.single_y;

  // A result appears only after an event has been worked through
  a_out_after_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ttpt_pkg::ST_CALC))
    else $error("result without a finished event");

  // The arithmetic unit finishes only while an event is in progress
  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ar_res.done |-> (state_q == ttpt_pkg::ST_CALC) && calc_q)
    else $error("arithmetic finished outside an event");

  // An update needs both contacts held
  a_upd_pinch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.update_valid |-> res_q.pinch_active && !res_q.single_present)
    else $error("update without two contacts");

endmodule

>>> dv/ttpt_checker.sv
module ttpt_checker
  import ttpt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ttpt_in_if   in_mon,
  ttpt_out_if  out_mon,
  output int   fail_cnt_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Mirror of the contact slots and the stored spread
  slot_t              trk_a;
  slot_t              trk_b;
  logic [SpreadW-1:0] prev_spread;

  res_t   expected_q[$];
  event_t seen_ev;
  int     mismatches = 0;
  int     queued     = 0;

  assign fail_cnt_o = mismatches;
  assign pending_o  = queued;

  // Floor of the Euclidean distance between the two contacts, unsigned Q17.0
  function automatic logic [SpreadW-1:0] contact_spread(slot_t a, slot_t b);
    longint            dx;
    longint            dy;
    longint unsigned   rem;
    longint unsigned   acc;
    longint unsigned   probe;
    dx    = longint'($signed(b.x)) - longint'($signed(a.x));
    dy    = longint'($signed(b.y)) - longint'($signed(a.y));
    rem   = longint'(dx * dx + dy * dy);
    acc   = 0;
    probe = 64'd1 << 34;
    while (probe > rem) probe >>= 2;
    // Restoring root, two bits of the radicand per step
    while (probe != 0) begin
      if (rem >= acc + probe) begin
        rem = rem - (acc + probe);
        acc = (acc >> 1) + probe;
      end else begin
        acc = acc >> 1;
      end
      probe >>= 2;
    end
    return acc[SpreadW-1:0];
  endfunction

  function automatic logic signed [PosW-1:0] floor_mid(logic signed [PosW-1:0] a,
                                                       logic signed [PosW-1:0] b);
    int sum;
    sum = int'(a) + int'(b);
    return PosW'(sum >>> 1);
  endfunction

  function automatic logic held(slot_t s, logic signed [IdW-1:0] id);
    return s.valid && (s.id == id);
  endfunction

  // Advance the slot mirror by one event and return the result it should give
  function automatic res_t apply_event(event_t ev);
    res_t               r;
    logic [SpreadW-1:0] cur;
    logic               hit;
    logic [63:0]        quo;
    r = '0;
    if (ev.action == ACT_RESET) begin
      trk_a       = '0;
      trk_b       = '0;
      prev_spread = '0;
    end else if (!ev.id[IdW-1]) begin
      case (ev.action)
        ACT_BEGIN: begin
          if (held(trk_a, ev.id)) begin
            trk_a.x = ev.x;
            trk_a.y = ev.y;
          end else if (held(trk_b, ev.id)) begin
            trk_b.x = ev.x;
            trk_b.y = ev.y;
          end else if (!trk_a.valid) begin
            trk_a = '{valid: 1'b1, id: ev.id, x: ev.x, y: ev.y};
          end else if (!trk_b.valid) begin
            trk_b       = '{valid: 1'b1, id: ev.id, x: ev.x, y: ev.y};
            prev_spread = contact_spread(trk_a, trk_b);
          end
        end
        ACT_MOVE: begin
          hit = 1'b1;
          if (held(trk_a, ev.id)) begin
            trk_a.x = ev.x;
            trk_a.y = ev.y;
          end else if (held(trk_b, ev.id)) begin
            trk_b.x = ev.x;
            trk_b.y = ev.y;
          end else begin
            hit = 1'b0;
          end
          if (hit && trk_a.valid && trk_b.valid) begin
            cur = contact_spread(trk_a, trk_b);
            // Emit only when both spreads are nonzero; store the new one regardless
            if (cur != '0 && prev_spread != '0) begin
              quo = 64'(cur) << RatioFracBits;
              quo = quo / 64'(prev_spread);
              r.zoom_ratio   = (quo > 64'(RatioMax)) ? RatioMax : quo[RatioW-1:0];
              r.mid_x        = floor_mid(trk_a.x, trk_b.x);
              r.mid_y        = floor_mid(trk_a.y, trk_b.y);
              r.update_valid = 1'b1;
            end
            prev_spread = cur;
          end
        end
        default: begin
          // End: drop the contact, promoting slot B when slot A goes
          if (held(trk_a, ev.id)) begin
            trk_a       = trk_b;
            trk_b       = '0;
            prev_spread = '0;
          end else if (held(trk_b, ev.id)) begin
            trk_b       = '0;
            prev_spread = '0;
          end
        end
      endcase
    end

    r.pinch_active   = trk_a.valid && trk_b.valid;
    r.id_tracked     = held(trk_a, ev.id) || held(trk_b, ev.id);
    r.single_present = trk_a.valid && !trk_b.valid;
    if (r.single_present) begin
      r.single_id = trk_a.id;
      r.single_x  = trk_a.x;
      r.single_y  = trk_a.y;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [63:0] exp_v,
                                      logic signed [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  function automatic void compare_result(res_t exp_r);
    check_field("update_valid", exp_r.update_valid, out_mon.update_valid);
    check_field("zoom_ratio", exp_r.zoom_ratio, out_mon.zoom_ratio);
    check_field("mid_x", exp_r.mid_x, out_mon.mid_x);
    check_field("mid_y", exp_r.mid_y, out_mon.mid_y);
    check_field("pinch_active", exp_r.pinch_active, out_mon.pinch_active);
    check_field("id_tracked", exp_r.id_tracked, out_mon.id_tracked);
    check_field("single_present", exp_r.single_present, out_mon.single_present);
    check_field("single_id", exp_r.single_id, out_mon.single_id);
    check_field("single_x", exp_r.single_x, out_mon.single_x);
    check_field("single_y", exp_r.single_y, out_mon.single_y);
  endfunction

  // Predict on each accepted event, compare each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_a       = '0;
      trk_b       = '0;
      prev_spread = '0;
      expected_q.delete();
      queued      = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        seen_ev.action = action_e'(in_mon.action);
        seen_ev.id     = in_mon.touch_id;
        seen_ev.x      = in_mon.pos_x;
        seen_ev.y      = in_mon.pos_y;
        expected_q.push_back(apply_event(seen_ev));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("result item arrived with no expectation waiting");
          mismatches++;
        end else begin
          compare_result(expected_q.pop_front());
        end
      end
      queued = expected_q.size();
    end
  end

endmodule

>>> dv/tb.sv
module tb
  import ttpt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PosMin       = -32768;
  localparam int PosMax       = 32767;
  localparam int GestureItems = 1150;

  logic clk_i;
  logic rst_ni;
  bit   steady_run = 1'b0;
  int   items_sent = 0;
  int   fail_cnt;
  int   pending_cnt;

  ttpt_in_if  in_ch ();
  ttpt_out_if out_ch ();

  two_touch_pinch_tracker i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  ttpt_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Stall the result side at random, except in the steady stretch
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready = steady_run || ($urandom_range(99) >= 32);
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL two_touch_pinch_tracker");
    $finish;
  end

  // Offer one touch event, with a random gap ahead of it, and hold until taken
  task automatic send_touch(action_e act, int id, int x, int y);
    @(negedge clk_i);
    while (!steady_run && $urandom_range(99) < 32) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid    = 1'b1;
    in_ch.action   = act;
    in_ch.touch_id = 8'(id);
    in_ch.pos_x    = 16'(x);
    in_ch.pos_y    = 16'(y);
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  function automatic logic signed [15:0] pick_pos(logic signed [15:0] centre);
    int r;
    r = $urandom_range(99);
    if (r < 60) return 16'(int'(centre) + int'($urandom_range(511)) - 256);
    if (r < 85) return 16'($urandom);
    case ($urandom_range(3))
      0:       return 16'(PosMin);
      1:       return 16'(PosMax);
      2:       return 16'sd0;
      default: return -16'sd1;
    endcase
  endfunction

  task automatic run_directed();
    send_touch(ACT_RESET, -128, PosMax, PosMin);
    send_touch(ACT_BEGIN, -1, 0, 0);
    send_touch(ACT_BEGIN, 0, PosMin, PosMin);
    send_touch(ACT_BEGIN, 127, PosMax, PosMax);
    send_touch(ACT_MOVE, 127, PosMax, PosMin);
    // coincident contacts, then a move away from a zero spread
    send_touch(ACT_MOVE, 0, PosMax, PosMin);
    send_touch(ACT_MOVE, 0, 0, 0);
    send_touch(ACT_BEGIN, 5, 100, 100);
    send_touch(ACT_BEGIN, 0, 0, 0);
    send_touch(ACT_MOVE, -1, 1, 1);
    send_touch(ACT_MOVE, 33, 1, 1);
    // tiny spread followed by a huge one saturates the ratio
    send_touch(ACT_MOVE, 127, 1, 0);
    send_touch(ACT_MOVE, 127, PosMax, PosMax);
    send_touch(ACT_MOVE, 127, -1, -1);
    send_touch(ACT_END, -5, 0, 0);
    send_touch(ACT_END, 0, 0, 0);
    send_touch(ACT_MOVE, 127, -100, 200);
    send_touch(ACT_END, 127, 0, 0);
    send_touch(ACT_END, 9, 0, 0);
    send_touch(ACT_BEGIN, 3, 50, -50);
    send_touch(ACT_BEGIN, 4, -50, 50);
    send_touch(ACT_END, 4, 0, 0);
    send_touch(ACT_RESET, 3, 0, 0);
  endtask

  // Two contacts down, a run of moves, then lift both in turn or clear everything
  task automatic play_gesture();
    int                 ids[2];
    logic signed [15:0] px[2];
    logic signed [15:0] py[2];
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    int                 moves;
    int                 who;
    int                 r;
    ids[0] = $urandom_range(127);
    ids[1] = (ids[0] + 1 + $urandom_range(126)) % 128;
    cx     = 16'($urandom);
    cy     = 16'($urandom);
    if ($urandom_range(99) < 30) send_touch(ACT_RESET, $urandom_range(255), 0, 0);
    for (int k = 0; k < 2; k++) begin
      px[k] = pick_pos(cx);
      py[k] = pick_pos(cy);
      send_touch(ACT_BEGIN, ids[k], px[k], py[k]);
    end
    moves = $urandom_range(1, 12);
    for (int m = 0; m < moves; m++) begin
      who = $urandom_range(1);
      r   = $urandom_range(99);
      if (r < 10) begin
        px[who] = px[1 - who];
        py[who] = py[1 - who];
      end else begin
        px[who] = pick_pos(cx);
        py[who] = pick_pos(cy);
      end
      send_touch(ACT_MOVE, ids[who], px[who], py[who]);
      // stray events from a third finger or a foreign id
      if ($urandom_range(99) < 8) begin
        send_touch($urandom_range(1) ? ACT_BEGIN : ACT_MOVE,
                   $urandom_range(255), $urandom, $urandom);
      end
    end
    r = $urandom_range(99);
    if (r < 80) begin
      who = (r < 40) ? 0 : 1;
      send_touch(ACT_END, ids[who], $urandom, $urandom);
      who = 1 - who;
      repeat ($urandom_range(3)) begin
        send_touch(ACT_MOVE, ids[who], pick_pos(cx), pick_pos(cy));
      end
      send_touch(ACT_END, ids[who], $urandom, $urandom);
    end else begin
      send_touch(ACT_RESET, $urandom_range(255), $urandom, $urandom);
    end
  endtask

  task automatic run_random();
    int first;
    first = items_sent;
    while (items_sent - first < GestureItems) begin
      steady_run = (items_sent - first >= 500) && (items_sent - first < 650);
      if ($urandom_range(99) < 12) begin
        send_touch(action_e'($urandom_range(3)), $urandom, $urandom, $urandom);
      end else begin
        play_gesture();
      end
    end
    steady_run = 1'b0;
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.action   = ACT_RESET;
    in_ch.touch_id = '0;
    in_ch.pos_x    = '0;
    in_ch.pos_y    = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    run_random();

    // Drain: wait for every result, then let the block settle
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    wait (pending_cnt == 0);
    repeat (80) @(posedge clk_i);

    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("PASS two_touch_pinch_tracker");
    end else begin
      $display("FAIL two_touch_pinch_tracker");
    end
    $finish;
  end

endmodule
